[rtl/core/ilid_pkg.sv]
// Shared types and codes for the indexed list insert/delete core.
package ilid_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [STAT_W-1:0]        t_status;

    localparam t_op OP_INSERT = 3'd0;
    localparam t_op OP_REMOVE = 3'd1;
    localparam t_op OP_READ   = 3'd2;
    localparam t_op OP_WRITE  = 3'd3;
    localparam t_op OP_CLEAR  = 3'd4;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
        logic wr;
    } t_cell_ctrl;

endpackage

[rtl/core/ilid_if.sv]
// Request and response channel interfaces for the indexed list core.
interface ilid_req_if #(
    parameter int POS_W = 5
);
    logic                 valid;
    logic                 ready;
    ilid_pkg::t_op        op;
    logic [POS_W-1:0]     position;
    ilid_pkg::t_word      value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ilid_rsp_if #(
    parameter int CNT_W = 5
);
    logic                 valid;
    logic                 ready;
    ilid_pkg::t_word      read_value;
    logic [CNT_W-1:0]     count;
    logic                 full_res;
    ilid_pkg::t_status    status;

    modport source (output valid, output read_value, output count, output full_res,
                    output status, input ready);
    modport sink   (input valid, input read_value, input count, input full_res,
                    input status, output ready);
endinterface

[rtl/core/ilid_cell.sv]
// One list slot: holds a word and shifts with its neighbors on insert/remove.
module ilid_cell #(
    parameter int IDX   = 0,
    parameter int POS_W = 5
) (
    input  logic                 i_clk,
    input  ilid_pkg::t_cell_ctrl i_ctrl,
    input  logic [POS_W-1:0]     i_pos,
    input  ilid_pkg::t_word      i_value,
    input  ilid_pkg::t_word      i_left,
    input  ilid_pkg::t_word      i_right,
    output ilid_pkg::t_word      o_entry,
    output ilid_pkg::t_word      o_tap
);
    import ilid_pkg::*;

    localparam logic [POS_W-1:0] IDX_C = POS_W'(IDX);

    t_word r_entry;
    t_word n_entry;
    logic  w_hit;
    logic  w_above;

    assign w_hit   = (i_pos == IDX_C);
    assign w_above = (IDX_C > i_pos);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (w_hit) begin
                n_entry = i_value;
            end else if (w_above) begin
                n_entry = i_left;
            end
        end else if (i_ctrl.rem) begin
            if (w_hit || w_above) begin
                n_entry = i_right;
            end
        end else if (i_ctrl.wr && w_hit) begin
            n_entry = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = w_hit ? r_entry : '0;
endmodule

[rtl/core/indexed_list_insert_delete_core.sv]
// Top level of the indexed list core: request decode, cell chain and response register.
//
// An ordered list of up to CAPACITY signed 32-bit words kept in a row of cells. Each
// request (insert, remove, read, write, clear) is done when taken: every cell compares
// its own slot number with the position and loads from its lower neighbor, its upper
// neighbor or the request word, so shifting needs no separate step. The response beat is
// registered and appears the cycle after the request beat; a new request is taken in any
// cycle in which the response register is empty or being drained, giving one request per
// cycle when the sink keeps ready high. The entry count is cleared by reset; slot contents
// are not and are reachable only after being written.
module indexed_list_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilid_req_if.sink   i_req,
    ilid_rsp_if.source o_rsp
);
    import ilid_pkg::*;

    localparam int               CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic             w_accept;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_full;
    logic             w_pos_lt;
    logic             w_pos_le;
    t_status          w_status;
    logic             w_rd_ok;
    t_cell_ctrl       w_ctrl;
    t_word            w_entry [CAPACITY];
    t_word            w_tap   [CAPACITY];
    t_word            w_rd_or;

    logic             r_rsp_valid;
    t_word            r_rd_value;
    logic [CNT_W-1:0] r_rsp_count;
    logic             r_rsp_full;
    t_status          r_rsp_status;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_full   = (r_count == CAP_C);
    assign w_pos_lt = (i_req.position < r_count);
    assign w_pos_le = (i_req.position <= r_count);

    always_comb begin
        w_ctrl   = '0;
        w_status = ST_DONE;
        w_rd_ok  = 1'b0;
        n_count  = r_count;
        unique case (i_req.op)
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (!w_pos_le) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.ins = w_accept;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!w_pos_lt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rem = w_accept;
                    n_count    = r_count - 1'b1;
                end
            end
            OP_READ: begin
                if (!w_pos_lt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            OP_WRITE: begin
                if (!w_pos_lt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.wr = w_accept;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        ilid_cell #(
            .IDX   (g),
            .POS_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_pos   (i_req.position),
            .i_value (i_req.value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_tap   (w_tap[g])
        );
    end

    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_or = w_rd_or | w_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_value   <= w_rd_ok ? w_rd_or : '0;
            r_rsp_count  <= n_count;
            r_rsp_full   <= (n_count == CAP_C);
            r_rsp_status <= w_status;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.read_value = r_rd_value;
    assign o_rsp.count      = r_rsp_count;
    assign o_rsp.full_res   = r_rsp_full;
    assign o_rsp.status     = r_rsp_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_full_insert_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.op == OP_INSERT && w_full |=> r_count == $past(r_count))
        else $error("insert into full list changed count");

    a_rsp_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> o_rsp.count == r_count)
        else $error("response count differs from list count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && o_rsp.status == ST_FULL |-> o_rsp.full_res)
        else $error("full status without full flag");
endmodule
